### hdl/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants for the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

    // Field widths fixed by the item format.
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int SYM_W  = 8;
    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;

    // Pending bits left over after whole bytes are sent (0 to 7 of them).
    localparam int PEND_W = BYTE_W - 1;

    // Working register: pending bits followed by one full-width code.
    localparam int ACC_W = CODE_W + PEND_W;
    localparam int CNT_W = $clog2(ACC_W + 1);

    // Queue between the table stage and the packer.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Item opcodes.
    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } opcode_t;

    // One unit of work for the packer.
    typedef struct packed {
        logic              is_flush;
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  len;
    } work_t;

endpackage

### hdl/hcbp_front.sv
// ----------------------------------------------------------------------------
// hcbp_front
// Accepts input items, keeps the code table, looks up encode symbols and
// hands encode and flush work to the queue.
// ----------------------------------------------------------------------------
module hcbp_front #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [hcbp_pkg::OP_W-1:0]  s_opcode,
    input  logic [hcbp_pkg::SYM_W-1:0] s_symbol,
    input  logic [hcbp_pkg::CODE_W-1:0] s_code_value,
    input  logic [hcbp_pkg::LEN_W-1:0] s_code_length,
    output logic                       q_push,
    output hcbp_pkg::work_t            q_data,
    input  logic                       q_full
);

    localparam int IDX_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int LEN_LIM = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ?
                             MAX_CODE_LEN : hcbp_pkg::CODE_W;

    // Code table storage; lengths are qualified by per-entry valid bits.
    logic [hcbp_pkg::CODE_W-1:0] bits_mem [SYMBOL_COUNT];
    logic [hcbp_pkg::LEN_W-1:0]  len_mem  [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0]     len_vld_reg;

    // Lookup stage registers.
    logic                        s1_valid_reg;
    logic                        s1_flush_reg;
    logic                        s1_hit_reg;
    logic [hcbp_pkg::LEN_W-1:0]  s1_len_reg;
    logic [hcbp_pkg::CODE_W-1:0] s1_bits_reg;

    logic                        accept;
    logic                        sym_ok;
    logic [IDX_W-1:0]            idx;
    logic                        is_load;
    logic                        is_encode;
    logic                        is_flush;
    logic [hcbp_pkg::LEN_W-1:0]  ld_len;
    logic [hcbp_pkg::CODE_W-1:0] ld_bits;
    logic                        tbl_write;
    logic [hcbp_pkg::LEN_W-1:0]  eff_len;
    logic                        s1_drop;
    logic                        s1_free;

    // Decode the incoming item.
    always_comb begin
        accept    = s_valid && s_ready;
        sym_ok    = {1'b0, s_symbol} < (hcbp_pkg::SYM_W + 1)'(SYMBOL_COUNT);
        idx       = s_symbol[IDX_W-1:0];
        is_load   = s_opcode == hcbp_pkg::OP_LOAD;
        is_encode = s_opcode == hcbp_pkg::OP_ENCODE;
        is_flush  = s_opcode == hcbp_pkg::OP_FLUSH;
        ld_len    = (s_code_length > hcbp_pkg::LEN_W'(LEN_LIM)) ?
                    hcbp_pkg::LEN_W'(LEN_LIM) : s_code_length;
        ld_bits   = s_code_value & ~({hcbp_pkg::CODE_W{1'b1}} << ld_len);
        tbl_write = accept && is_load && sym_ok;
    end

    // A looked-up symbol of length zero produces nothing and is dropped here.
    always_comb begin
        eff_len = s1_hit_reg ? s1_len_reg : '0;
        s1_drop = !s1_flush_reg && (eff_len == '0);
        s1_free = !s1_valid_reg || s1_drop || !q_full;
        s_ready = s1_free;
        q_push  = s1_valid_reg && !s1_drop && !q_full;
        q_data.is_flush = s1_flush_reg;
        q_data.bits     = s1_bits_reg;
        q_data.len      = eff_len;
    end

    // Control state: stage occupancy and table valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            len_vld_reg  <= '0;
        end else begin
            if (s1_free) begin
                s1_valid_reg <= accept && ((is_encode && sym_ok) || is_flush);
            end
            if (tbl_write) begin
                len_vld_reg[idx] <= 1'b1;
            end
        end
    end

    // Table writes and registered table reads.
    always_ff @(posedge aclk) begin
        if (tbl_write) begin
            bits_mem[idx] <= ld_bits;
            len_mem[idx]  <= ld_len;
        end
        if (s1_free) begin
            s1_flush_reg <= is_flush;
            s1_hit_reg   <= len_vld_reg[idx];
            s1_len_reg   <= len_mem[idx];
            s1_bits_reg  <= bits_mem[idx];
        end
    end

endmodule

### hdl/hcbp_queue.sv
// ----------------------------------------------------------------------------
// hcbp_queue
// Short first-in first-out queue of packer work between the two halves.
// ----------------------------------------------------------------------------
module hcbp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  hcbp_pkg::work_t wr_data,
    output logic            full,
    input  logic            pop,
    output hcbp_pkg::work_t rd_data,
    output logic            empty
);

    hcbp_pkg::work_t               entry_reg [hcbp_pkg::QUEUE_DEPTH];
    logic [hcbp_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [hcbp_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [hcbp_pkg::QPTR_W:0]     count_reg;

    // Status flags and head entry.
    always_comb begin
        full    = count_reg == (hcbp_pkg::QPTR_W + 1)'(hcbp_pkg::QUEUE_DEPTH);
        empty   = count_reg == '0;
        rd_data = entry_reg[rd_ptr_reg];
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hdl/hcbp_back.sv
// ----------------------------------------------------------------------------
// hcbp_back
// Bit packer: appends codes to the pending bits and sends one byte per
// cycle through the output register while the receiver is ready.
// ----------------------------------------------------------------------------
module hcbp_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_empty,
    input  hcbp_pkg::work_t             q_data,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [hcbp_pkg::BYTE_W-1:0] m_out_byte,
    output logic                        m_last
);

    logic [hcbp_pkg::ACC_W-1:0]  acc_reg,  acc_next;
    logic [hcbp_pkg::CNT_W-1:0]  cnt_reg,  cnt_next;
    logic                        m_valid_reg, m_valid_next;
    logic [hcbp_pkg::BYTE_W-1:0] m_byte_reg,  m_byte_next;
    logic                        m_last_reg,  m_last_next;

    logic                        out_free;
    logic                        have_byte;
    logic                        emit;
    logic [hcbp_pkg::PEND_W-1:0] pend;
    logic [hcbp_pkg::CNT_W-1:0]  emit_sh;
    logic [hcbp_pkg::BYTE_W-1:0] pad_byte;

    // Next-state logic for the pending bits and the output register.
    always_comb begin
        out_free  = !m_valid_reg || m_ready;
        have_byte = cnt_reg >= hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W);
        emit      = have_byte && out_free;
        q_pop     = !have_byte && !q_empty && (!q_data.is_flush || out_free);
        pend      = acc_reg[hcbp_pkg::PEND_W-1:0] &
                    ~({hcbp_pkg::PEND_W{1'b1}} << cnt_reg);
        emit_sh   = cnt_reg - hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W);
        pad_byte  = {1'b0, pend} << (hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W) - cnt_reg);

        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;

        if (emit) begin
            // Send the oldest eight bits; the last byte leaves fewer than eight.
            cnt_next     = emit_sh;
            m_valid_next = 1'b1;
            m_byte_next  = hcbp_pkg::BYTE_W'(acc_reg >> emit_sh);
            m_last_next  = emit_sh < hcbp_pkg::CNT_W'(hcbp_pkg::BYTE_W);
        end else if (q_pop) begin
            if (q_data.is_flush) begin
                // Pad the pending bits with zeros; an empty buffer sends nothing.
                cnt_next = '0;
                acc_next = '0;
                if (cnt_reg != '0) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = pad_byte;
                    m_last_next  = 1'b1;
                end
            end else begin
                acc_next = (hcbp_pkg::ACC_W'(pend) << q_data.len) |
                           hcbp_pkg::ACC_W'(q_data.bits);
                cnt_next = cnt_reg + hcbp_pkg::CNT_W'(q_data.len);
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_last     = m_last_reg;

endmodule

### hdl/huffman_code_bit_packer_top.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_top
// Huffman encoder back end: code table, work queue and byte packer.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on the s_ channel (valid/ready). A load writes one code
// table entry, an encode appends that symbol's code to the pending bits, and
// a flush pads the pending bits with zeros and sends one byte.
// Packed bytes leave on the m_ channel (valid/ready); m_last marks the final
// byte caused by one input item. Loads, unknown symbols, zero-length codes
// and flushes of an empty buffer cause no transfer.
// Path: the first byte of an encode passes through the table read, the queue
// and the packing to the output register; the remaining bytes follow one per
// cycle while the receiver is ready. The packer takes a new code only while
// fewer than eight bits are pending, so an item's whole bytes leave before
// the next code enters; with short codes and a ready receiver the block
// sustains about one item per cycle. On a receiver stall the output register
// holds its byte, the two-entry queue fills, then s_ready drops. Reset clears
// the pending bits, the queue and all table valid bits at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_top #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [hcbp_pkg::OP_W-1:0]   s_opcode,
    input  logic [hcbp_pkg::SYM_W-1:0]  s_symbol,
    input  logic [hcbp_pkg::CODE_W-1:0] s_code_value,
    input  logic [hcbp_pkg::LEN_W-1:0]  s_code_length,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [hcbp_pkg::BYTE_W-1:0] m_out_byte,
    output logic                        m_last
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    hcbp_pkg::work_t q_wr_data;
    hcbp_pkg::work_t q_rd_data;

    // Front: table and lookup.
    hcbp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_symbol      (s_symbol),
        .s_code_value  (s_code_value),
        .s_code_length (s_code_length),
        .q_push        (q_push),
        .q_data        (q_wr_data),
        .q_full        (q_full)
    );

    // Work queue between the halves.
    hcbp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // Back: bit packer and output register.
    hcbp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_data     (q_rd_data),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

endmodule
